### design/sawc_pkg.sv
package sawc_pkg;

	localparam int OFFSET_BITS_DEF  = 4;
	localparam int SET_BITS_MAX_DEF = 6;
	localparam int WAYS_DEF         = 4;
	localparam int ADDR_BITS_DEF    = 32;

	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_SET_BITS    = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAYS_IN_USE = 1'd1;

	localparam int OP_BITS   = 2;
	localparam int ADDR_W    = 32;
	localparam int WAY_OUT_W = 2;

	localparam logic [OP_BITS-1:0] OP_READ  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd2;
	localparam logic [OP_BITS-1:0] OP_PROBE = 2'd3;

	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic [ADDR_W-1:0]  address;
	} in_item_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 writeback;
		logic [ADDR_W-1:0]    writeback_address;
		logic                 fill;
		logic [ADDR_W-1:0]    fill_address;
		logic                 last;
	} out_item_t;

endpackage

### design/set_assoc_writeback_cache_tags.sv
// tag and state side of a set-associative write-back cache with true lru.
// a read, write or probe passes through the back end as pop, tag and
// metadata ram read, then compare with result and update; a flush passes
// pop and ram read, then gives one result per active way; the registered-read
// rams and the single update per set set this order. the result is
// registered, and while out_stall holds it the back end waits with it.
// a two-entry queue lets the front take items while the back works or
// its result waits. after reset the back end clears the valid, dirty and
// lru metadata ram over all 1 << SET_BITS_MAX sets (64 by default); the queue
// still takes two items meanwhile. tags are only read after being written.
// configuration: 0 set_bits, 1 ways_in_use, write only while idle.
module set_assoc_writeback_cache_tags #(
	parameter int OFFSET_BITS  = sawc_pkg::OFFSET_BITS_DEF,
	parameter int SET_BITS_MAX = sawc_pkg::SET_BITS_MAX_DEF,
	parameter int WAYS         = sawc_pkg::WAYS_DEF,
	parameter int ADDR_BITS    = sawc_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sawc_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sawc_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [sawc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [sawc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int SIDX_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
	localparam int TAG_W  = ADDR_BITS - OFFSET_BITS;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [2:0] set_bits_q, ways_in_use_q;
	logic [2:0] sb_eff;
	logic [WAY_W:0] ways_eff;

	// config registers, clamped to what the hardware holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd6;
			ways_in_use_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				sawc_pkg::REG_SET_BITS:    set_bits_q <= cfg_data;
				sawc_pkg::REG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sb_eff = (int'(set_bits_q) > SET_BITS_MAX) ? 3'(SET_BITS_MAX) : set_bits_q;
		if (ways_in_use_q == 3'd0) ways_eff = (WAY_W+1)'(1);
		else if (int'(ways_in_use_q) > WAYS) ways_eff = (WAY_W+1)'(WAYS);
		else ways_eff = (WAY_W+1)'(ways_in_use_q);
	end

	logic q_valid, q_pop;
	logic [sawc_pkg::OP_BITS-1:0] q_op;
	logic [SIDX_W-1:0] q_set;
	logic [TAG_W-1:0]  q_tag;
	logic [ADDR_BITS-1:0] q_addr;

	sawc_front #(.OFFSET_BITS(OFFSET_BITS),
		.ADDR_BITS(ADDR_BITS), .SIDX_W(SIDX_W), .TAG_W(TAG_W)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .sb_eff(sb_eff), .q_valid(q_valid), .q_pop(q_pop),
		.q_op(q_op), .q_set(q_set), .q_tag(q_tag), .q_addr(q_addr));

	sawc_back #(.OFFSET_BITS(OFFSET_BITS), .SET_BITS_MAX(SET_BITS_MAX), .WAYS(WAYS),
		.ADDR_BITS(ADDR_BITS), .SIDX_W(SIDX_W), .TAG_W(TAG_W), .WAY_W(WAY_W)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op),
		.q_set(q_set), .q_tag(q_tag), .q_addr(q_addr), .sb_eff(sb_eff),
		.ways_eff(ways_eff), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_item));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_item))
		else $error("stalled item changed");

endmodule

### design/sawc_ram.sv
module sawc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/sawc_front.sv
// decode and queue: holds up to two decoded items for the back end
module sawc_front #(
	parameter int OFFSET_BITS  = sawc_pkg::OFFSET_BITS_DEF,
	parameter int ADDR_BITS    = sawc_pkg::ADDR_BITS_DEF,
	parameter int SIDX_W       = 1,
	parameter int TAG_W        = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sawc_pkg::in_item_t              in_item,
	input  logic [2:0]                      sb_eff,
	output logic                            q_valid,
	input  logic                            q_pop,
	output logic [sawc_pkg::OP_BITS-1:0]    q_op,
	output logic [SIDX_W-1:0]               q_set,
	output logic [TAG_W-1:0]                q_tag,
	output logic [ADDR_BITS-1:0]            q_addr
);

	typedef struct packed {
		logic [sawc_pkg::OP_BITS-1:0] op;
		logic [SIDX_W-1:0]            set;
		logic [TAG_W-1:0]             tag;
		logic [ADDR_BITS-1:0]         addr;
	} dec_t;

	dec_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	dec_t       dec;
	logic [ADDR_BITS-1:0] a;
	logic       push;

	always_comb begin
		a = ADDR_BITS'(in_item.address);
		dec.op = in_item.op;
		dec.addr = a;
		dec.set = SIDX_W'((a >> OFFSET_BITS) & ~({ADDR_BITS{1'b1}} << sb_eff));
		dec.tag = TAG_W'(a >> (OFFSET_BITS + int'(sb_eff)));
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = ent_q[rp_q].op;
	assign q_set    = ent_q[rp_q].set;
	assign q_tag    = ent_q[rp_q].tag;
	assign q_addr   = ent_q[rp_q].addr;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> in_stall) else $error("full queue took item");

endmodule

### design/sawc_back.sv
// executes one queued item: tag and metadata read, compare, result, state update
module sawc_back #(
	parameter int OFFSET_BITS  = sawc_pkg::OFFSET_BITS_DEF,
	parameter int SET_BITS_MAX = sawc_pkg::SET_BITS_MAX_DEF,
	parameter int WAYS         = sawc_pkg::WAYS_DEF,
	parameter int ADDR_BITS    = sawc_pkg::ADDR_BITS_DEF,
	parameter int SIDX_W       = 1,
	parameter int TAG_W        = 1,
	parameter int WAY_W        = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_pop,
	input  logic [sawc_pkg::OP_BITS-1:0] q_op,
	input  logic [SIDX_W-1:0]            q_set,
	input  logic [TAG_W-1:0]             q_tag,
	input  logic [ADDR_BITS-1:0]         q_addr,
	input  logic [2:0]                   sb_eff,
	input  logic [WAY_W:0]               ways_eff,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sawc_pkg::out_item_t          out_item
);

	localparam int NSETS  = 1 << SET_BITS_MAX;
	localparam int OUT_AW = sawc_pkg::ADDR_W;
	localparam int OUT_WW = sawc_pkg::WAY_OUT_W;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_FLUSH} state_t;

	// per-set metadata word: lru order (index 0 oldest), dirty and valid bits
	typedef struct packed {
		logic [WAYS-1:0][WAY_W-1:0] lru;
		logic [WAYS-1:0]            dirty;
		logic [WAYS-1:0]            valid;
	} meta_t;

	state_t state_q;
	logic [SIDX_W-1:0] clr_q;
	logic [sawc_pkg::OP_BITS-1:0] op_q;
	logic [SIDX_W-1:0] set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WAY_W-1:0] fw_q;
	logic [WAY_W:0]   ways_q;
	logic [2:0]       sb_q;

	// tag store: one ram per way, all read at the set
	logic [TAG_W-1:0] rtag [WAYS];
	logic [WAYS-1:0]  twe;

	// metadata store, cleared by a pass over all sets after reset
	meta_t             rmeta, wmeta;
	logic              mwe;
	logic [SIDX_W-1:0] mwaddr;

	for (genvar w = 0; w < WAYS; w++) begin : g_tag
		sawc_ram #(.WIDTH(TAG_W), .DEPTH(NSETS)) u_tag (
			.clk(clk), .we(twe[w]), .waddr(set_q), .wdata(tag_q),
			.raddr(set_q), .rdata(rtag[w]));
	end

	sawc_ram #(.WIDTH($bits(meta_t)), .DEPTH(NSETS)) u_meta (
		.clk(clk), .we(mwe), .waddr(mwaddr), .wdata(wmeta),
		.raddr(set_q), .rdata(rmeta));

	logic             found;
	logic [WAY_W-1:0] fway, victim, sel;
	logic             vd;
	logic [ADDR_BITS-1:0] vaddr;
	logic [ADDR_BITS-1:0] tagx;
	logic             last_way;
	logic             hitp;
	logic [WAYS-1:0][WAY_W-1:0] lru_new;
	logic             is_access, is_probe;
	logic             can_out, emit;
	sawc_pkg::out_item_t nxt;

	assign is_access = (op_q == sawc_pkg::OP_READ) || (op_q == sawc_pkg::OP_WRITE);
	assign is_probe  = (op_q == sawc_pkg::OP_PROBE);
	assign can_out   = !out_valid || !out_stall;
	assign emit      = (state_q == ST_EXEC || state_q == ST_FLUSH) && can_out;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		found = 1'b0;
		fway = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if ((WAY_W+1)'(w) < ways_q && rmeta.valid[w] && rtag[w] == tag_q) begin
				found = 1'b1;
				fway = WAY_W'(w);
			end
		end
		victim = '0;
		for (int p = WAYS - 1; p >= 0; p--) begin
			if ({1'b0, rmeta.lru[p]} < ways_q) victim = rmeta.lru[p];
		end
		sel = (state_q == ST_FLUSH) ? fw_q : (found ? fway : victim);
		vd = rmeta.valid[sel] && rmeta.dirty[sel];
		tagx = ADDR_BITS'(rtag[sel]);
		vaddr = ((tagx << sb_q) | ADDR_BITS'(set_q)) << OFFSET_BITS;
		last_way = (({1'b0, fw_q} + 1'b1) == ways_q);
		// move the used way to the young end
		hitp = 1'b0;
		lru_new = rmeta.lru;
		for (int p = 0; p < WAYS - 1; p++) begin
			if (rmeta.lru[p] == sel) hitp = 1'b1;
			if (hitp) lru_new[p] = rmeta.lru[p + 1];
		end
		lru_new[WAYS - 1] = sel;
	end

	always_comb begin
		twe = '0;
		if (state_q == ST_EXEC && !found && is_access && can_out) begin
			twe[victim] = 1'b1;
		end
	end

	always_comb begin
		wmeta = rmeta;
		mwe = 1'b0;
		mwaddr = set_q;
		case (state_q)
			ST_CLEAR: begin
				mwe = 1'b1;
				mwaddr = clr_q;
				wmeta.valid = '0;
				wmeta.dirty = '0;
				for (int w = 0; w < WAYS; w++) wmeta.lru[w] = WAY_W'(w);
			end
			ST_EXEC: begin
				if (can_out && is_access) begin
					mwe = 1'b1;
					wmeta.lru = lru_new;
					if (!found) begin
						wmeta.valid[victim] = 1'b1;
						wmeta.dirty[victim] = (op_q == sawc_pkg::OP_WRITE);
					end else if (op_q == sawc_pkg::OP_WRITE) begin
						wmeta.dirty[fway] = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				// all active ways of the set are invalidated with the final result
				if (can_out && last_way) begin
					mwe = 1'b1;
					for (int w = 0; w < WAYS; w++) begin
						if ((WAY_W+1)'(w) < ways_q) begin
							wmeta.valid[w] = 1'b0;
							wmeta.dirty[w] = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		nxt = '0;
		if (state_q == ST_FLUSH) begin
			nxt.way = OUT_WW'(fw_q);
			nxt.writeback = vd;
			nxt.writeback_address = vd ? OUT_AW'(vaddr) : '0;
			nxt.last = last_way;
		end else begin
			nxt.last = 1'b1;
			nxt.hit = found;
			if (is_probe) begin
				nxt.way = found ? OUT_WW'(fway) : '0;
			end else begin
				nxt.way = OUT_WW'(sel);
				if (!found) begin
					nxt.writeback = vd;
					nxt.writeback_address = vd ? OUT_AW'(vaddr) : '0;
					nxt.fill = 1'b1;
					nxt.fill_address = OUT_AW'(addr_q & ({ADDR_BITS{1'b1}} << OFFSET_BITS));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
			set_q <= q_set;
			tag_q <= q_tag;
			addr_q <= q_addr;
			ways_q <= ways_eff;
			sb_q <= sb_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
			fw_q <= '0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				out_item <= nxt;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SIDX_W'(NSETS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) state_q <= ST_READ;
				end
				ST_READ: begin
					fw_q <= '0;
					state_q <= (op_q == sawc_pkg::OP_FLUSH) ? ST_FLUSH : ST_EXEC;
				end
				ST_EXEC: begin
					if (can_out) state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (can_out) begin
						if (last_way) begin
							state_q <= ST_IDLE;
						end else begin
							fw_q <= fw_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_READ) else $error("pop outside idle");
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.fill) |-> !out_item.hit) else $error("fill on hit");
	a_wb_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(twe)) else $error("multiple tag writes");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid && !q_pop) else $error("item during clear");

endmodule
